// File: rtl/core/tgd_pkg.sv
// shared types, character codes and the 5x7 font for the glyph display core
`timescale 1ns / 1ps
package tgd_pkg;

  localparam int DEF_TEXT_ROWS   = 8;
  localparam int DEF_TEXT_COLS   = 21;
  localparam int DEF_PIXEL_WIDTH = 128;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_SEEN   = 2'd1;
  localparam logic [1:0] ESC_CSI    = 2'd2;

  localparam logic [7:0] ESC_CHAR   = 8'h1b;
  localparam logic [7:0] CR_CHAR    = 8'h0d;
  localparam logic [7:0] LF_CHAR    = 8'h0a;
  localparam logic [7:0] BS_CHAR    = 8'h08;
  localparam logic [7:0] DEL_CHAR   = 8'h7f;
  localparam logic [7:0] CSI_CHAR   = 8'h5b;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7e;
  localparam logic [7:0] PRINT_HI   = 8'h7e;

  localparam logic [6:0] SPACE_CELL = 7'h20;
  localparam logic [7:0] PITCH      = 8'd6;
  localparam logic [2:0] GLYPH_COLS = 3'd5;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_in;
    logic [2:0] page;
    logic [6:0] x;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [2:0] cursor_row;
    logic [4:0] cursor_column;
    logic [1:0] escape_state;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_BYTE
  } state_t;

  // glyph columns in reading order, leftmost column in the top byte
  function automatic logic [7:0] glyph_column(logic [6:0] ch, logic [2:0] idx);
    logic [6:0]  c;
    logic [39:0] g;
    c = ch;
    if (c >= 7'h61 && c <= 7'h7a) begin
      c = c - 7'h20;
    end
    case (c)
      7'h41: g = 40'h7e1111117e;
      7'h42: g = 40'h7f49494936;
      7'h43: g = 40'h3e41414122;
      7'h44: g = 40'h7f4141221c;
      7'h45: g = 40'h7f49494941;
      7'h46: g = 40'h7f09090901;
      7'h47: g = 40'h3e4149497a;
      7'h48: g = 40'h7f0808087f;
      7'h49: g = 40'h00417f4100;
      7'h4a: g = 40'h2040413f01;
      7'h4b: g = 40'h7f08142241;
      7'h4c: g = 40'h7f40404040;
      7'h4d: g = 40'h7f020c027f;
      7'h4e: g = 40'h7f0408107f;
      7'h4f: g = 40'h3e4141413e;
      7'h50: g = 40'h7f09090906;
      7'h51: g = 40'h3e4151215e;
      7'h52: g = 40'h7f09192946;
      7'h53: g = 40'h4649494931;
      7'h54: g = 40'h01017f0101;
      7'h55: g = 40'h3f4040403f;
      7'h56: g = 40'h1f2040201f;
      7'h57: g = 40'h3f4038403f;
      7'h58: g = 40'h6314081463;
      7'h59: g = 40'h0708700807;
      7'h5a: g = 40'h6151494543;
      7'h30: g = 40'h3e5149453e;
      7'h31: g = 40'h00427f4000;
      7'h32: g = 40'h4261514946;
      7'h33: g = 40'h2141454b31;
      7'h34: g = 40'h1814127f10;
      7'h35: g = 40'h2745454539;
      7'h36: g = 40'h3c4a494930;
      7'h37: g = 40'h0171090503;
      7'h38: g = 40'h3649494936;
      7'h39: g = 40'h064949291e;
      7'h2e: g = 40'h0060600000;
      7'h3a: g = 40'h0036360000;
      7'h2d: g = 40'h0808080808;
      7'h2f: g = 40'h2010080402;
      7'h3e: g = 40'h0041221408;
      default: g = '0;
    endcase
    if (idx >= GLYPH_COLS) begin
      return 8'h00;
    end
    return g[(4 - int'(idx)) * 8 +: 8];
  endfunction

endpackage

// File: rtl/core/tgd_step_unit.sv
// shared subtract and compare unit used by the sequencer
`timescale 1ns / 1ps
module tgd_step_unit #(
  parameter int W = 8
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);
  logic [W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];
endmodule

// File: rtl/core/tgd_cell_ram.sv
// character cell memory with per-cell valid bits, invalid cells read as space
`timescale 1ns / 1ps
module tgd_cell_ram #(
  parameter int ROWS = tgd_pkg::DEF_TEXT_ROWS,
  parameter int COLS = tgd_pkg::DEF_TEXT_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(ROWS*COLS)-1:0]    addr,
  input  logic                            we,
  input  logic [6:0]                      wdata,
  input  logic                            clr,
  input  logic [$clog2(ROWS)-1:0]         clr_row,
  output logic [6:0]                      rdata
);
  import tgd_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int ROW_W = $clog2(ROWS);

  logic [6:0]       mem [CELLS];
  logic [CELLS-1:0] valid;
  logic [6:0]       data_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    data_q  <= mem[addr];
    valid_q <= valid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          if (clr && clr_row == ROW_W'(r)) begin
            valid[r * COLS + c] <= 1'b0;
          end
        end
      end
      if (we) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  assign rdata = valid_q ? data_q : SPACE_CELL;
endmodule

// File: rtl/core/text_terminal_glyph_display_core.sv
// text terminal core: character grid, cursor, escape skipping and font readout
//
// usage: drive item and raise start; the item is taken at a rising edge where
// start is high and busy is low. busy stays high while the item is worked on.
// each item gives exactly one result, shown on result for one cycle with done
// high; the receiver cannot stall, so it must take result in that cycle.
// a shell byte item (cmd 0) updates cursor, escape state and the grid, and
// its done strobe follows the wrap and byte states.
// a read item (cmd 1) returns one column of pixels of one page; the column
// x is split into text column and glyph column by repeated subtraction of
// the 6-pixel pitch in the shared subtractor, one step a cycle, before the
// cell is read and its glyph column is looked up.
// busy drops with done, so a new item may be started in the done cycle.
// scrolling moves a top-row pointer and clears the valid bits of one row,
// so it needs no states beyond those of the byte item.
// reset (rst, synchronous) shows an all-space grid, cursor at the top left
// and no escape in progress; the block is ready in the cycle after reset.
`timescale 1ns / 1ps
module text_terminal_glyph_display_core #(
  parameter int TEXT_ROWS   = tgd_pkg::DEF_TEXT_ROWS,
  parameter int TEXT_COLS   = tgd_pkg::DEF_TEXT_COLS,
  parameter int PIXEL_WIDTH = tgd_pkg::DEF_PIXEL_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tgd_pkg::item_t  item,
  output logic            busy,
  output logic            done,
  output tgd_pkg::result_t result
);
  import tgd_pkg::*;

  localparam int ROW_W  = $clog2(TEXT_ROWS);
  localparam int COL_W  = $clog2(TEXT_COLS);
  localparam int ADDR_W = $clog2(TEXT_ROWS * TEXT_COLS);

  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(TEXT_COLS - 1);
  localparam logic [7:0]        ROWS_W8   = 8'(TEXT_ROWS);
  localparam logic [7:0]        PIX_LIMIT = 8'(PIXEL_WIDTH);
  localparam logic [4:0]        COLS_Q    = 5'(TEXT_COLS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(TEXT_COLS);

  state_t            state, state_next;
  item_t             item_q;
  logic [6:0]        rem, rem_next;
  logic [4:0]        quot, quot_next;
  logic [ROW_W-1:0]  phys, phys_next;
  logic [ROW_W-1:0]  line, line_next;
  logic [COL_W-1:0]  col, col_next;
  logic [1:0]        phase, phase_next;
  logic [ROW_W-1:0]  top_row, top_row_next;
  result_t           result_next;
  logic              done_next;

  logic [7:0]        su_a, su_b, su_diff;
  logic              su_ge;
  logic [2:0]        row_src;

  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic              ram_clr;
  logic [6:0]        ram_rdata;
  logic              in_range;
  logic              new_line;
  logic [7:0]        ch;

  tgd_step_unit #(.W(8)) u_step (
    .a    (su_a),
    .b    (su_b),
    .diff (su_diff),
    .ge   (su_ge)
  );

  tgd_cell_ram #(.ROWS(TEXT_ROWS), .COLS(TEXT_COLS)) u_ram (
    .clk     (clk),
    .rst     (rst),
    .addr    (ram_addr),
    .we      (ram_we),
    .wdata   (ch[6:0]),
    .clr     (ram_clr),
    .clr_row (top_row),
    .rdata   (ram_rdata)
  );

  assign busy    = (state != ST_IDLE);
  assign ch      = item_q.byte_in;
  assign row_src = (item_q.cmd == CMD_READ) ? item_q.page : 3'(line);

  assign in_range = ({1'b0, item_q.page} < 4'(TEXT_ROWS)) &&
                    ({1'b0, item_q.x} < PIX_LIMIT) && (quot < COLS_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      line    <= '0;
      col     <= '0;
      phase   <= ESC_NORMAL;
      top_row <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      line    <= line_next;
      col     <= col_next;
      phase   <= phase_next;
      top_row <= top_row_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
      rem    <= item.x;
      quot   <= '0;
    end else begin
      rem    <= rem_next;
      quot   <= quot_next;
    end
    phys   <= phys_next;
    result <= result_next;
  end

  always_comb begin
    state_next   = state;
    rem_next     = rem;
    quot_next    = quot;
    phys_next    = phys;
    line_next    = line;
    col_next     = col;
    phase_next   = phase;
    top_row_next = top_row;
    result_next  = result;
    done_next    = 1'b0;
    ram_addr     = '0;
    ram_we       = 1'b0;
    ram_clr      = 1'b0;
    new_line     = 1'b0;
    su_a         = {1'b0, rem};
    su_b         = PITCH;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        su_a       = 8'(row_src) + 8'(top_row);
        su_b       = ROWS_W8;
        phys_next  = su_ge ? su_diff[ROW_W-1:0] : su_a[ROW_W-1:0];
        state_next = (item_q.cmd == CMD_READ) ? ST_DIV : ST_BYTE;
      end
      ST_DIV: begin
        if (su_ge) begin
          rem_next  = su_diff[6:0];
          quot_next = quot + 5'd1;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (in_range) begin
          ram_addr = ADDR_W'(phys) * COLS_A + ADDR_W'(quot);
        end
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        result_next.frame_byte    = in_range ? glyph_column(ram_rdata, rem[2:0]) : 8'h00;
        result_next.cursor_row    = 3'(line);
        result_next.cursor_column = 5'(col);
        result_next.escape_state  = phase;
        done_next                 = 1'b1;
        state_next                = ST_IDLE;
      end
      ST_BYTE: begin
        ram_addr = ADDR_W'(phys) * COLS_A + ADDR_W'(col);
        priority if (phase != ESC_NORMAL) begin
          if (phase == ESC_SEEN && ch == CSI_CHAR) begin
            phase_next = ESC_CSI;
          end else if (ch >= FINAL_LO && ch <= FINAL_HI) begin
            phase_next = ESC_NORMAL;
          end
        end else if (ch == ESC_CHAR) begin
          phase_next = ESC_SEEN;
        end else if (ch == CR_CHAR) begin
          col_next = '0;
        end else if (ch == LF_CHAR) begin
          new_line = 1'b1;
        end else if (ch == BS_CHAR || ch == DEL_CHAR) begin
          if (col != '0) begin
            col_next = col - COL_W'(1);
          end
        end else if (ch >= SPACE_CHAR && ch <= PRINT_HI) begin
          ram_we = 1'b1;
          if (col == COL_LAST) begin
            new_line = 1'b1;
          end else begin
            col_next = col + COL_W'(1);
          end
        end else begin
          col_next = col;
        end
        if (new_line) begin
          col_next = '0;
          if (line == ROW_LAST) begin
            ram_clr      = 1'b1;
            top_row_next = (top_row == ROW_LAST) ? '0 : top_row + ROW_W'(1);
          end else begin
            line_next = line + ROW_W'(1);
          end
        end
        result_next.frame_byte    = 8'h00;
        result_next.cursor_row    = 3'(line_next);
        result_next.cursor_column = 5'(col_next);
        result_next.escape_state  = phase_next;
        done_next                 = 1'b1;
        state_next                = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

// File: rtl/core/tgd_checker.sv
// port-level checks for the glyph display core and their bind
`timescale 1ns / 1ps
module tgd_assertions (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input tgd_pkg::result_t result
);
  import tgd_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the core busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("item finished without a result");

  a_escape_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.escape_state == ESC_NORMAL || result.escape_state == ESC_SEEN ||
              result.escape_state == ESC_CSI))
    else $error("escape state out of range");
endmodule

bind text_terminal_glyph_display_core tgd_assertions u_tgd_assertions (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// File: tb/tgd_checker.sv
// checker for the glyph display core: predicts each result and compares it
`timescale 1ns / 1ps
module tgd_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  tgd_pkg::item_t   item,
  input  logic             done,
  input  tgd_pkg::result_t result,
  output int unsigned      fail_count,
  output int unsigned      results_due
);
  import tgd_pkg::*;

  localparam int ROWS  = DEF_TEXT_ROWS;
  localparam int COLS  = DEF_TEXT_COLS;
  localparam int WIDTH = DEF_PIXEL_WIDTH;

  logic [6:0]  grid [ROWS*COLS];
  int          row_q;
  int          col_q;
  logic [1:0]  esc_q;
  result_t     due_q [$];
  int unsigned mismatches;

  function automatic logic [7:0] font_column(logic [6:0] ch, int idx);
    logic [6:0]  up;
    logic [39:0] cols;
    up = (ch >= 7'h61 && ch <= 7'h7a) ? ch - 7'h20 : ch;
    case (up)
      "A": cols = 40'h7e1111117e;
      "B": cols = 40'h7f49494936;
      "C": cols = 40'h3e41414122;
      "D": cols = 40'h7f4141221c;
      "E": cols = 40'h7f49494941;
      "F": cols = 40'h7f09090901;
      "G": cols = 40'h3e4149497a;
      "H": cols = 40'h7f0808087f;
      "I": cols = 40'h00417f4100;
      "J": cols = 40'h2040413f01;
      "K": cols = 40'h7f08142241;
      "L": cols = 40'h7f40404040;
      "M": cols = 40'h7f020c027f;
      "N": cols = 40'h7f0408107f;
      "O": cols = 40'h3e4141413e;
      "P": cols = 40'h7f09090906;
      "Q": cols = 40'h3e4151215e;
      "R": cols = 40'h7f09192946;
      "S": cols = 40'h4649494931;
      "T": cols = 40'h01017f0101;
      "U": cols = 40'h3f4040403f;
      "V": cols = 40'h1f2040201f;
      "W": cols = 40'h3f4038403f;
      "X": cols = 40'h6314081463;
      "Y": cols = 40'h0708700807;
      "Z": cols = 40'h6151494543;
      "0": cols = 40'h3e5149453e;
      "1": cols = 40'h00427f4000;
      "2": cols = 40'h4261514946;
      "3": cols = 40'h2141454b31;
      "4": cols = 40'h1814127f10;
      "5": cols = 40'h2745454539;
      "6": cols = 40'h3c4a494930;
      "7": cols = 40'h0171090503;
      "8": cols = 40'h3649494936;
      "9": cols = 40'h064949291e;
      ".": cols = 40'h0060600000;
      ":": cols = 40'h0036360000;
      "-": cols = 40'h0808080808;
      "/": cols = 40'h2010080402;
      ">": cols = 40'h0041221408;
      default: cols = '0;
    endcase
    if (idx >= 5) begin
      return 8'h00;
    end
    return cols[39 - 8*idx -: 8];
  endfunction

  function automatic void clear_screen();
    for (int i = 0; i < ROWS*COLS; i++) begin
      grid[i] = SPACE_CELL;
    end
    row_q = 0;
    col_q = 0;
    esc_q = ESC_NORMAL;
  endfunction

  function automatic void new_line();
    col_q = 0;
    row_q++;
    if (row_q >= ROWS) begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) begin
        grid[i] = grid[i + COLS];
      end
      for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) begin
        grid[i] = SPACE_CELL;
      end
      row_q = ROWS - 1;
    end
  endfunction

  function automatic void feed_byte(logic [7:0] ch);
    if (esc_q != ESC_NORMAL) begin
      if (esc_q == ESC_SEEN && ch == CSI_CHAR) begin
        esc_q = ESC_CSI;
      end else if (ch >= FINAL_LO && ch <= FINAL_HI) begin
        esc_q = ESC_NORMAL;
      end
    end else if (ch == ESC_CHAR) begin
      esc_q = ESC_SEEN;
    end else if (ch == CR_CHAR) begin
      col_q = 0;
    end else if (ch == LF_CHAR) begin
      new_line();
    end else if (ch == BS_CHAR || ch == DEL_CHAR) begin
      if (col_q != 0) begin
        col_q--;
      end
    end else if (ch >= SPACE_CHAR && ch <= PRINT_HI) begin
      grid[row_q*COLS + col_q] = ch[6:0];
      col_q++;
      if (col_q >= COLS) begin
        new_line();
      end
    end
  endfunction

  function automatic logic [7:0] page_pixels(int page, int x);
    int col;
    if (page >= ROWS || x >= WIDTH) begin
      return 8'h00;
    end
    col = x / int'(PITCH);
    if (col >= COLS) begin
      return 8'h00;
    end
    return font_column(grid[page*COLS + col], x % int'(PITCH));
  endfunction

  function automatic result_t next_result(item_t it);
    result_t r;
    r.frame_byte = 8'h00;
    if (it.cmd == CMD_BYTE) begin
      feed_byte(it.byte_in);
    end else begin
      r.frame_byte = page_pixels(int'(it.page), int'(it.x));
    end
    r.cursor_row    = 3'(row_q);
    r.cursor_column = 5'(col_q);
    r.escape_state  = esc_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    mismatches = 0;
    clear_screen();
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_screen();
      due_q.delete();
    end else begin
      if (done) begin
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, result);
        end else begin
          want = due_q.pop_front();
          check_field("frame_byte", want.frame_byte, result.frame_byte);
          check_field("cursor_row", 8'(want.cursor_row), 8'(result.cursor_row));
          check_field("cursor_column", 8'(want.cursor_column), 8'(result.cursor_column));
          check_field("escape_state", 8'(want.escape_state), 8'(result.escape_state));
        end
      end
      if (start && !busy) begin
        due_q.push_back(next_result(item));
      end
    end
    fail_count  <= mismatches;
    results_due <= due_q.size();
  end

endmodule

// File: tb/tb_top.sv
// testbench top for the glyph display core: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
  import tgd_pkg::*;

  localparam int ITEM_COUNT  = 1400;
  localparam int STALL_LIMIT = 600;

  logic        clk;
  logic        rst;
  logic        start;
  item_t       item;
  logic        busy;
  logic        done;
  result_t     result;
  int unsigned fail_count;
  int unsigned results_due;
  int unsigned quiet_cycles;
  int          sent;
  bit          calm;

  text_terminal_glyph_display_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  tgd_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic item_t byte_item(logic [7:0] b);
    item_t it;
    it.cmd     = CMD_BYTE;
    it.byte_in = b;
    it.page    = 3'($urandom);
    it.x       = 7'($urandom);
    return it;
  endfunction

  function automatic item_t read_item(logic [2:0] p, logic [6:0] x);
    item_t it;
    it.cmd     = CMD_READ;
    it.byte_in = 8'($urandom);
    it.page    = p;
    it.x       = x;
    return it;
  endfunction

  function automatic logic [7:0] glyph_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'h41, 8'h5a));
      1: return 8'($urandom_range(8'h61, 8'h7a));
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: begin
        case ($urandom_range(0, 4))
          0: return ".";
          1: return ":";
          2: return "-";
          3: return "/";
          default: return ">";
        endcase
      end
      default: return 8'($urandom_range(SPACE_CHAR, PRINT_HI));
    endcase
  endfunction

  task automatic send_item(item_t it);
    if (!calm && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_escape();
    send_item(byte_item(ESC_CHAR));
    if ($urandom_range(0, 9) < 8) begin
      send_item(byte_item(CSI_CHAR));
      repeat ($urandom_range(0, 3)) begin
        send_item(byte_item(8'($urandom_range(8'h30, 8'h3b))));
      end
    end else if ($urandom_range(0, 3) == 0) begin
      send_item(byte_item(8'($urandom_range(0, 8'h3f))));
    end
    send_item(byte_item(8'($urandom_range(FINAL_LO, FINAL_HI))));
  endtask

  initial begin
    int pick;
    rst          <= 1'b1;
    start        <= 1'b0;
    item         <= '0;
    sent = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed items
    send_item(read_item(3'd0, 7'd0));
    send_item(byte_item("A"));
    send_item(read_item(3'd0, 7'd0));
    send_item(byte_item("z"));
    send_item(read_item(3'd0, 7'd8));
    send_item(read_item(3'd0, 7'd11));
    send_item(byte_item(BS_CHAR));
    send_item(byte_item(DEL_CHAR));
    send_item(byte_item(DEL_CHAR));
    send_item(byte_item(DEL_CHAR));
    send_item(byte_item(8'h7e));
    send_item(byte_item(CR_CHAR));
    send_item(byte_item(LF_CHAR));
    send_item(byte_item(ESC_CHAR));
    send_item(byte_item(CSI_CHAR));
    send_item(byte_item("3"));
    send_item(byte_item("m"));
    send_item(byte_item(ESC_CHAR));
    send_item(byte_item(LF_CHAR));
    send_item(byte_item("x"));
    send_item(byte_item(8'h00));
    send_item(byte_item(8'hff));
    send_item(byte_item(8'h80));
    send_item(read_item(3'd7, 7'd127));
    send_item(read_item(3'd0, 7'd120));

    // random items, mostly text with escape sequences and reads
    while (sent < ITEM_COUNT) begin
      calm = (sent >= 600 && sent < 800);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(read_item(3'($urandom), 7'($urandom)));
      end else if (pick < 70) begin
        send_item(byte_item(glyph_char()));
      end else if (pick < 78) begin
        send_item(byte_item(LF_CHAR));
      end else if (pick < 81) begin
        send_item(byte_item(CR_CHAR));
      end else if (pick < 85) begin
        send_item(byte_item($urandom_range(0, 1) ? BS_CHAR : DEL_CHAR));
      end else if (pick < 92) begin
        send_escape();
      end else begin
        send_item(byte_item(8'($urandom)));
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
